>>> hdl/swub_pkg.sv
`default_nettype none
package swub_pkg;
  localparam int SLOTS_DEF = 32;
  localparam logic [31:0] WINDOW_RST = 32'd10000000;
  localparam logic [16:0] TARGET_RST = 17'd45875;
  localparam logic [31:0] MAXGC_RST = 32'd500000;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam int DIV_STEPS = 16;

  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_TARGET = 2'd1,
    CFG_MAXGC  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        we;
    logic [31:0] len;
    logic        app;
  } slot_wr_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction
endpackage
`default_nettype wire

>>> hdl/sliding_window_utilization_budget_unit.sv
`default_nettype none
// Sliding-window utilization budget.
// Input channel (in_valid_i/in_ready_o): a timestamp now_ns_i and an owner
// flag is_app_time_i for the time since the previous word.
// Output channel (out_valid_o/out_ready_i): utilization (Q1.16), collector
// budget in ns, a compaction flag and the echoed timestamp; one per input.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i at once.
// One word at a time: in_ready_o is high only while the sequencer is idle.
// Per word the sequencer walks up to U+1 slots to trim the window and moves
// the kept slots down (U = live slots before the word, at most SLOTS-1),
// with a step for a backwards stamp, compaction, the serial Q0.16 divider
// when the share is below one, the budget multiply and clamp, and the
// output register load. The slot memory port and the one-bit-a-cycle
// divider set how long a word takes.
// A finished result sits in the output register; the next word is taken
// meanwhile and waits at its end only if that register is still full.
// Reset restores the register defaults, a single application slot of the
// full window, and a last time of zero; no clearing pass is needed.
module sliding_window_utilization_budget_unit import swub_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] now_ns_i,
  input  wire logic        is_app_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [16:0]      utilization_o,
  output logic [31:0]      gc_budget_ns_o,
  output logic             compacted_o,
  output logic [63:0]      echo_time_ns_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int IDX = $clog2(SLOTS);
  localparam int CNT = $clog2(SLOTS + 1);
  localparam int SUM = 32 + IDX + 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_BACK  = 12'b000000000010,
    S_TRD   = 12'b000000000100,
    S_TCMP  = 12'b000000001000,
    S_MRD   = 12'b000000010000,
    S_MWR   = 12'b000000100000,
    S_CMP0  = 12'b000001000000,
    S_CMP1  = 12'b000010000000,
    S_DINIT = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_BMUL  = 12'b010000000000,
    S_BUD   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] window_q, maxgc_q;
  logic [16:0] target_q;
  logic [63:0] last_q, now_q, elapsed_q, rem_q, first_q;
  logic        app_q, comp_q, done_q;
  logic [IDX-1:0] used_q, idx_q, start_q, src_q;
  logic [SUM-1:0] sum_q;
  logic [31:0] r_q;
  logic [15:0] q_q;
  logic [4:0]  cnt_q;
  logic [16:0] util_q;
  logic [31:0] budget_q;

  logic [31:0] rlen;
  logic        rapp;
  slot_wr_t    wr;
  logic [IDX-1:0] waddr, raddr;
  logic [16:0] mul_a, rest;
  logic [48:0] prod;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE) && !done_q;
  assign in_acc = in_valid_i && in_ready_o;
  assign rest = (target_q >= ONE_Q16) ? 17'd0 : ONE_Q16 - target_q;
  assign mul_a = (state_q == S_IDLE) ? rest : util_q - target_q;

  swub_mul u_mul (.clk_i, .a_i(mul_a), .b_i(window_q), .p_o(prod));

  swub_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i, .rst_ni, .wr_i(wr), .waddr_i(waddr), .raddr_i(raddr),
    .rlen_o(rlen), .rapp_o(rapp)
  );

  logic [63:0] cur_len, mv_val;
  logic        mv_own;
  logic [31:0] mv32;
  logic [CNT-1:0] n_new;
  logic [32:0] r2;

  always_comb begin
    cur_len = (idx_q == used_q) ? elapsed_q : {32'd0, rlen};
    mv_own  = (src_q == used_q) ? app_q : rapp;
    if (src_q == start_q) begin
      mv_val = first_q;
    end else if (src_q == used_q) begin
      mv_val = elapsed_q;
    end else begin
      mv_val = {32'd0, rlen};
    end
    mv32  = sat32(mv_val);
    n_new = CNT'(used_q) - CNT'(start_q) + CNT'(1);
    r2    = {r_q, 1'b0};
    raddr = (state_q == S_MRD) ? src_q : idx_q;
    wr    = '0;
    waddr = src_q - start_q;
    unique case (state_q)
      S_MWR: begin
        wr = '{we: 1'b1, len: mv32, app: mv_own};
      end
      S_CMP0: begin
        wr = '{we: 1'b1, len: sat32(64'(sum_q)), app: 1'b1};
        waddr = '0;
      end
      S_CMP1: begin
        wr = '{we: 1'b1,
               len: (sum_q >= SUM'(window_q)) ? 32'd0 : window_q - sum_q[31:0],
               app: 1'b0};
        waddr = IDX'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RST;
      target_q <= TARGET_RST;
      maxgc_q  <= MAXGC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW: window_q <= cfg_data_i;
        CFG_TARGET: target_q <= cfg_data_i[16:0];
        CFG_MAXGC:  maxgc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      used_q      <= IDX'(1);
      done_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        last_q <= now_ns_i;
      end
      if (state_q == S_MWR && src_q == used_q && n_new != CNT'(SLOTS)) begin
        used_q <= n_new[IDX-1:0];
      end
      if (state_q == S_CMP1) begin
        used_q <= IDX'(2);
      end
      if (state_q == S_BUD) begin
        done_q <= 1'b1;
      end else if (done_q && (!out_valid_o || out_ready_i)) begin
        done_q <= 1'b0;
      end
      if (done_q && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = (now_ns_i < last_q) ? S_BACK : S_TRD;
      S_BACK:  state_d = S_TRD;
      S_TRD:   state_d = S_TCMP;
      S_TCMP:  state_d = (idx_q != used_q && rem_q > cur_len) ? S_TRD : S_MRD;
      S_MRD:   state_d = S_MWR;
      S_MWR: begin
        if (src_q == used_q) begin
          state_d = (n_new == CNT'(SLOTS)) ? S_CMP0 : S_DINIT;
        end else begin
          state_d = S_MRD;
        end
      end
      S_CMP0:  state_d = S_CMP1;
      S_CMP1:  state_d = S_DINIT;
      S_DINIT: state_d = (window_q == '0 || sum_q >= SUM'(window_q)) ? S_BMUL : S_DIV;
      S_DIV:   if (cnt_q == 5'd1) state_d = S_BMUL;
      S_BMUL:  state_d = S_BUD;
      S_BUD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          now_q     <= now_ns_i;
          app_q     <= is_app_time_i;
          elapsed_q <= now_ns_i - last_q;
          rem_q     <= now_ns_i - last_q;
          idx_q     <= '0;
          comp_q    <= 1'b0;
        end
      end
      S_BACK: begin
        elapsed_q <= 64'(prod[48:16]);
        rem_q     <= 64'(prod[48:16]);
        app_q     <= 1'b0;
      end
      S_TCMP: begin
        if (idx_q != used_q && rem_q > cur_len) begin
          rem_q <= rem_q - cur_len;
          idx_q <= idx_q + IDX'(1);
        end else begin
          first_q <= (cur_len >= rem_q) ? cur_len - rem_q : 64'd0;
          start_q <= idx_q;
          src_q   <= idx_q;
          sum_q   <= '0;
        end
      end
      S_MWR: begin
        if (mv_own) sum_q <= sum_q + SUM'(mv32);
        src_q <= src_q + IDX'(1);
      end
      S_CMP1: comp_q <= 1'b1;
      S_DINIT: begin
        r_q   <= sum_q[31:0];
        q_q   <= '0;
        cnt_q <= 5'(DIV_STEPS);
        if (window_q == '0) begin
          util_q <= '0;
        end else if (sum_q >= SUM'(window_q)) begin
          util_q <= ONE_Q16;
        end
      end
      S_DIV: begin
        if (r2 >= {1'b0, window_q}) begin
          r_q <= 32'(r2 - {1'b0, window_q});
        end else begin
          r_q <= r2[31:0];
        end
        q_q   <= {q_q[14:0], r2 >= {1'b0, window_q}};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) util_q <= {1'b0, q_q[14:0], r2 >= {1'b0, window_q}};
      end
      S_BUD: begin
        if (util_q > target_q) begin
          budget_q <= (33'(prod[48:16]) < {1'b0, maxgc_q}) ? prod[47:16] : maxgc_q;
        end else begin
          budget_q <= '0;
        end
      end
      default: ;
    endcase
    if (done_q && (!out_valid_o || out_ready_i)) begin
      utilization_o  <= util_q;
      gc_budget_ns_o <= budget_q;
      compacted_o    <= comp_q;
      echo_time_ns_o <= now_q;
    end
  end

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != '0 && 32'(used_q) < SLOTS) else $error("live slot count out of range");
  a_trim_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TCMP |-> idx_q <= used_q) else $error("trim walk past last slot");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("ready while busy");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BUD |=> done_q) else $error("finished word not held");
endmodule
`default_nettype wire

>>> hdl/swub_slot_mem.sv
`default_nettype none
module swub_slot_mem import swub_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDX = $clog2(SLOTS)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire slot_wr_t       wr_i,
  input  wire logic [IDX-1:0] waddr_i,
  input  wire logic [IDX-1:0] raddr_i,
  output logic [31:0]         rlen_o,
  output logic                rapp_o
);
  logic [32:0] mem [SLOTS];
  logic [32:0] rd_q;
  logic        fresh_q, fresh_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[waddr_i] <= {wr_i.app, wr_i.len};
    end
    rd_q <= mem[raddr_i];
  end

  // slot 0 holds the reset window until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q    <= 1'b1;
      fresh_rd_q <= 1'b0;
    end else begin
      fresh_rd_q <= fresh_q && (raddr_i == '0);
      if (wr_i.we && waddr_i == '0) begin
        fresh_q <= 1'b0;
      end
    end
  end

  assign rlen_o = fresh_rd_q ? WINDOW_RST : rd_q[31:0];
  assign rapp_o = fresh_rd_q ? 1'b1 : rd_q[32];
endmodule
`default_nettype wire

>>> hdl/swub_mul.sv
`default_nettype none
module swub_mul import swub_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [16:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [48:0]      p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= 49'(a_i) * 49'(b_i);
  end
endmodule
`default_nettype wire

>>> sim/swub_budget_checker.sv
`timescale 1ns / 1ps
module swub_budget_checker import swub_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [63:0] now_ns_i,
  input  wire logic        is_app_time_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [16:0] utilization_i,
  input  wire logic [31:0] gc_budget_ns_i,
  input  wire logic        compacted_i,
  input  wire logic [63:0] echo_time_ns_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output int               errors_o,
  output int               outstanding_o,
  output int               checked_o,
  output int               compactions_o
);
  localparam int NSLOT = SLOTS_DEF;

  typedef struct packed {
    logic [16:0] util;
    logic [31:0] budget;
    logic        comp;
    logic [63:0] echo;
  } budget_word_t;

  logic [31:0] win_r, maxgc_r;
  logic [16:0] target_r;
  logic [31:0] slot_len[NSLOT];
  bit          slot_app[NSLOT];
  int          live;
  logic [63:0] last_ts;
  budget_word_t budget_q[$];

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic budget_word_t advance_window(input logic [63:0] now, input bit app_in);
    logic [63:0] seg[NSLOT];
    bit          seg_app[NSLOT];
    logic [63:0] elapsed, rem, app_sum, share, excess;
    logic [16:0] rest;
    int          n, first;
    bit          app, comp;
    budget_word_t w;
    app = app_in;
    comp = 0;
    if (live >= NSLOT) live = NSLOT - 1;
    if (now >= last_ts) begin
      elapsed = now - last_ts;
    end else begin
      rest = (target_r >= ONE_Q16) ? 17'd0 : ONE_Q16 - target_r;
      elapsed = (64'(win_r) * 64'(rest)) >> 16;
      app = 0;
    end
    last_ts = now;
    n = live;
    for (int i = 0; i < n; i++) begin
      seg[i] = 64'(slot_len[i]);
      seg_app[i] = slot_app[i];
    end
    seg[n] = elapsed;
    seg_app[n] = app;
    n++;
    rem = elapsed;
    first = 0;
    while (first + 1 < n && rem > seg[first]) begin
      rem -= seg[first];
      first++;
    end
    seg[first] = (seg[first] >= rem) ? seg[first] - rem : 64'd0;
    n -= first;
    for (int i = 0; i < NSLOT; i++) begin
      slot_len[i] = (i < n) ? clip32(seg[i + first]) : 32'd0;
      slot_app[i] = (i < n) ? seg_app[i + first] : 1'b0;
    end
    app_sum = 0;
    for (int i = 0; i < n; i++)
      if (slot_app[i]) app_sum += 64'(slot_len[i]);
    if (n >= NSLOT) begin
      comp = 1;
      for (int i = 2; i < NSLOT; i++) begin
        slot_len[i] = 0;
        slot_app[i] = 0;
      end
      slot_len[0] = clip32(app_sum);
      slot_app[0] = 1;
      slot_len[1] = (app_sum >= 64'(win_r)) ? 32'd0 : win_r - app_sum[31:0];
      slot_app[1] = 0;
      n = 2;
    end
    live = n;
    if (win_r == 0) share = 0;
    else share = (app_sum << 16) / 64'(win_r);
    if (share > 64'(ONE_Q16)) share = 64'(ONE_Q16);
    w.util = share[16:0];
    if (w.util > target_r) begin
      excess = (64'(w.util - target_r) * 64'(win_r)) >> 16;
      w.budget = (excess < 64'(maxgc_r)) ? excess[31:0] : maxgc_r;
    end else begin
      w.budget = 0;
    end
    w.comp = comp;
    w.echo = now;
    return w;
  endfunction

  assign outstanding_o = budget_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    budget_word_t e;
    if (!rst_ni) begin
      win_r = WINDOW_RST;
      target_r = TARGET_RST;
      maxgc_r = MAXGC_RST;
      for (int i = 0; i < NSLOT; i++) begin
        slot_len[i] = 0;
        slot_app[i] = 0;
      end
      slot_len[0] = WINDOW_RST;
      slot_app[0] = 1;
      live = 1;
      last_ts = 0;
      budget_q.delete();
      errors_o = 0;
      checked_o = 0;
      compactions_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (budget_q.size() == 0) begin
          $error("result word with nothing expected");
          errors_o++;
        end else begin
          e = budget_q.pop_front();
          checked_o++;
          if (e.comp) compactions_o++;
          if (utilization_i !== e.util) begin
            $error("utilization: expected %0d, got %0d", e.util, utilization_i);
            errors_o++;
          end
          if (gc_budget_ns_i !== e.budget) begin
            $error("gc_budget_ns: expected %0d, got %0d", e.budget, gc_budget_ns_i);
            errors_o++;
          end
          if (compacted_i !== e.comp) begin
            $error("compacted: expected %0d, got %0d", e.comp, compacted_i);
            errors_o++;
          end
          if (echo_time_ns_i !== e.echo) begin
            $error("echo_time_ns: expected %0h, got %0h", e.echo, echo_time_ns_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        budget_q.push_back(advance_window(now_ns_i, is_app_time_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW: win_r = cfg_data_i;
          CFG_TARGET: target_r = cfg_data_i[16:0];
          CFG_MAXGC:  maxgc_r = cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

>>> sim/tb_sliding_window_utilization_budget_unit.sv
`timescale 1ns / 1ps
module tb_sliding_window_utilization_budget_unit;
  import swub_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [63:0] now_ns = 0;
  logic        is_app = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [16:0] util;
  logic [31:0] budget;
  logic        comp;
  logic [63:0] echo;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = CFG_WINDOW;
  logic [31:0] cfg_data = 0;

  int          errors, outstanding, checked, compactions;
  int          cycles = 0;
  int          stall_left = 0;
  int          backsteps = 0;
  int          settings = 0;
  bit          quiet = 0;
  logic [63:0] ts = 0;
  logic [31:0] cur_win = WINDOW_RST;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  sliding_window_utilization_budget_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .now_ns_i(now_ns), .is_app_time_i(is_app),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .utilization_o(util), .gc_budget_ns_o(budget),
    .compacted_o(comp), .echo_time_ns_o(echo),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  swub_budget_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .now_ns_i(now_ns), .is_app_time_i(is_app),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .utilization_i(util), .gc_budget_ns_i(budget),
    .compacted_i(comp), .echo_time_ns_i(echo),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .outstanding_o(outstanding),
    .checked_o(checked), .compactions_o(compactions)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sliding_window_utilization_budget_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // called right after an edge; returns at the edge where the word is taken
  task automatic send_stamp(input logic [63:0] t, input bit app);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (t < ts) backsteps++;
    ts = t;
    in_valid <= 1'b1;
    now_ns <= t;
    is_app <= app;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic load_config(input logic [31:0] w, input logic [16:0] tgt,
                             input logic [31:0] mx);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WINDOW;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_idx <= CFG_TARGET;
    cfg_data <= {15'd0, tgt};
    @(posedge clk_i);
    cfg_idx <= CFG_MAXGC;
    cfg_data <= mx;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_win = w;
    settings++;
  endtask

  task automatic random_stamps(input int count, input int app_pct);
    logic [63:0] t;
    int          pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      t = ts + $urandom_range(0, cur_win / 20 + 1);
      else if (pick < 80) t = ts + $urandom_range(0, cur_win) + $urandom_range(0, cur_win);
      else if (pick < 88) t = ts - $urandom_range(1, cur_win / 4 + 2);
      else if (pick < 94) t = ts;
      else                t = {$urandom, $urandom};
      send_stamp(t, $urandom_range(0, 99) < app_pct);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: zero elapsed, both owners, long jump, backwards, top of range
    send_stamp(64'd0, 1);
    send_stamp(64'd0, 0);
    for (int k = 0; k < 6; k++) send_stamp(ts + 64'd250000, 1);
    send_stamp(ts + 64'd100000, 0);
    send_stamp(ts + 64'd30000000, 1);
    send_stamp(ts + 64'd30000000, 0);
    send_stamp(ts - 64'd5, 1);
    send_stamp(64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_stamp(64'h0, 1);
    send_stamp(64'h5555_5555_AAAA_AAAA, 0);
    send_stamp(64'hAAAA_AAAA_5555_5555, 1);
    for (int k = 0; k < 6; k++) send_stamp(ts + 64'd1000, k[0]);
    random_stamps(150, 85);

    load_config(32'd1, 17'd0, 32'd0);
    random_stamps(150, 50);
    load_config(32'hFFFF_FFFF, ONE_Q16, 32'hFFFF_FFFF);
    random_stamps(150, 90);
    load_config(32'd0, TARGET_RST, MAXGC_RST);
    random_stamps(100, 60);
    load_config(32'd1000, 17'h1FFFF, 32'd100);
    random_stamps(200, 80);
    // window shrinks under live slices: no renormalization
    load_config(32'd40, 17'd32768, 32'd7);
    random_stamps(200, 70);
    for (int p = 0; p < 3; p++) begin
      load_config($urandom_range(50, 100000), 17'($urandom_range(0, 65536)),
                  $urandom_range(0, 20000));
      random_stamps(200, $urandom_range(30, 95));
    end
    load_config(32'd10000, 17'd20000, 32'd3000);
    quiet = 1;
    random_stamps(150, 80);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("checked %0d result words (%0d compactions), %0d backward stamps,",
             checked, compactions, backsteps);
    $display("across %0d register settings plus the reset defaults", settings);
    if (errors == 0) begin
      $display("tb_sliding_window_utilization_budget_unit: done, clean");
    end else begin
      $display("tb_sliding_window_utilization_budget_unit: done, errors");
    end
    $finish;
  end
endmodule
